>>> design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the frame free-list allocator
// Field widths, command and status codes, config register indexes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED_OUTSIDE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED       = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the request at the port this cycle
        logic load_pop;  // load the popped stack entry into the result
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pop_pending;  // the request at the port will pop the stack
    } t_dp_stat;

endpackage

>>> design/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl: request sequencer of the frame free-list allocator
// Takes one request at a time, waits in S_POP for the stack read on a pop,
// and holds the result until the output transfer completes.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  ffa_pkg::t_dp_stat  i_stat,
    output ffa_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.pop_pending ? S_POP : S_RESP;
                end
            end
            S_POP: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshake and datapath commands
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = (r_state == S_RESP);
    assign o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.load_pop  = (r_state == S_POP);

endmodule

>>> design/ffa_datapath.sv
// ----------------------------------------------------------------------------
// ffa_datapath: free stack, bump counter and result registers
// Holds the region config, the LIFO free stack memory with its depth, the
// fresh-frame counter, and the registered result of the current request.
// ----------------------------------------------------------------------------
module ffa_datapath #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ffa_pkg::FRAME_W-1:0]         i_cfg_data,
    input  logic                                i_command,
    input  logic [ffa_pkg::FRAME_W-1:0]         i_frame_number,
    input  ffa_pkg::t_ctrl_cmd                  i_cmd,
    output ffa_pkg::t_dp_stat                   o_stat,
    output logic [ffa_pkg::FRAME_W-1:0]         o_granted_frame,
    output logic [ffa_pkg::STATUS_W-1:0]        o_status
);

    localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W  = $clog2(MAX_FRAMES);
    localparam int CW      = (DEPTH_W > ffa_pkg::COUNT_W) ? DEPTH_W : ffa_pkg::COUNT_W;
    localparam int EW      = ((CW > ffa_pkg::FRAME_W) ? CW : ffa_pkg::FRAME_W) + 1;

    logic [ffa_pkg::FRAME_W-1:0] r_first;
    logic [ffa_pkg::COUNT_W-1:0] r_count;
    logic [DEPTH_W-1:0]          r_depth;
    logic [DEPTH_W-1:0]          n_depth;
    logic [CW-1:0]               r_fresh;
    logic [CW-1:0]               n_fresh;
    logic [ffa_pkg::FRAME_W-1:0] r_granted;
    logic [ffa_pkg::FRAME_W-1:0] n_granted;
    logic [ffa_pkg::STATUS_W-1:0] r_status;
    logic [ffa_pkg::STATUS_W-1:0] n_status;
    logic [ffa_pkg::FRAME_W-1:0] r_rd_data;

    logic [ffa_pkg::FRAME_W-1:0] mem [MAX_FRAMES];

    logic [CW-1:0]     count_ext;
    logic [CW-1:0]     usable;
    logic [EW-1:0]     region_end;
    logic              outside;
    logic              stack_full;
    logic              stack_empty;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Clamp the frame count to the stack capacity
    assign count_ext = CW'(r_count);
    assign usable    = (count_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : count_ext;

    // Region test on the full-width end, so no frame wraps into the region
    assign region_end = EW'(r_first) + EW'(usable);
    assign outside    = (i_frame_number < r_first) || (EW'(i_frame_number) >= region_end);

    assign stack_full  = (r_depth == DEPTH_W'(MAX_FRAMES));
    assign stack_empty = (r_depth == '0);
    assign wr_addr     = r_depth[ADDR_W-1:0];
    assign rd_addr     = ADDR_W'(r_depth - DEPTH_W'(1));

    assign o_stat.pop_pending = (i_command == ffa_pkg::CMD_ALLOC) && !stack_empty;

    assign mem_we = i_cmd.accept && (i_command == ffa_pkg::CMD_FREE) && !stack_full;
    assign mem_re = i_cmd.accept && o_stat.pop_pending;

    // Request handling: counters and result
    always_comb begin
        n_depth   = r_depth;
        n_fresh   = r_fresh;
        n_granted = r_granted;
        n_status  = r_status;
        if (i_cmd.accept) begin
            n_granted = '0;
            if (i_command == ffa_pkg::CMD_ALLOC) begin
                if (!stack_empty) begin
                    n_depth  = r_depth - DEPTH_W'(1);
                    n_status = ffa_pkg::ST_ALLOC_OK;
                end else if (r_fresh >= usable) begin
                    n_status = ffa_pkg::ST_EXHAUSTED;
                end else begin
                    n_granted = ffa_pkg::FRAME_W'(EW'(r_first) + EW'(r_fresh));
                    n_fresh   = r_fresh + CW'(1);
                    n_status  = ffa_pkg::ST_ALLOC_OK;
                end
            end else begin
                if (stack_full) begin
                    n_status = ffa_pkg::ST_DROPPED;
                end else begin
                    n_depth  = r_depth + DEPTH_W'(1);
                    n_status = outside ? ffa_pkg::ST_FREED_OUTSIDE : ffa_pkg::ST_FREED;
                end
            end
        end else if (i_cmd.load_pop) begin
            n_granted = r_rd_data;
        end
    end

    // Config registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_count <= '0;
            r_depth <= '0;
            r_fresh <= '0;
        end else begin
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ffa_pkg::CFG_FIRST_FRAME: r_first <= i_cfg_data;
                    ffa_pkg::CFG_FRAME_COUNT: r_count <= i_cfg_data[ffa_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    // Free stack memory: push writes, pop reads into a register
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_frame_number;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_granted_frame = r_granted;
    assign o_status        = r_status;

endmodule

>>> design/frame_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// frame_free_list_allocator_top: physical frame allocator
// LIFO free stack in front of a bump counter over a configurable region.
// ----------------------------------------------------------------------------
// One request is handled at a time. A free, a fresh allocation and an
// exhaustion report present output valid in the cycle right after the input
// transfer; an allocation that pops the free stack presents it after the
// extra S_POP state, as the stack memory has registered read data.
// The next request is taken once the result transfer completes. Granted
// frame is zero unless the status is alloc ok. Register writes take effect
// at once and keep the stack and the fresh counter. The stack needs no
// clearing after reset: only entries below the current depth are ever read.
module frame_free_list_allocator_top #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ffa_pkg::FRAME_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [ffa_pkg::FRAME_W-1:0]   i_frame_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffa_pkg::FRAME_W-1:0]   o_granted_frame,
    output logic [ffa_pkg::STATUS_W-1:0]  o_status
);

    ffa_pkg::t_ctrl_cmd ctrl_cmd;
    ffa_pkg::t_dp_stat  dp_stat;

    // Sequencer
    ffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (ctrl_cmd)
    );

    // Stack, counters and result
    ffa_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_frame_number  (i_frame_number),
        .i_cmd           (ctrl_cmd),
        .o_stat          (dp_stat),
        .o_granted_frame (o_granted_frame),
        .o_status        (o_status)
    );

endmodule
